// ===== rtl/ftr_pkg.sv =====
// Shared constants and types for the fan duty from temperature rise block.
package ftr_pkg;

   // Field widths.
   localparam int ADC_W    = 12;
   localparam int SENSOR_W = 16;
   localparam int CAL_W    = 12;
   localparam int PERIOD_W = 16;
   localparam int TEMP_W   = 16;
   localparam int RISE_W   = 8;
   localparam int SPAN_W   = 16;

   // The ambient result keeps 12 bits of (prod >> 8) + offset, so the product is needed
   // only modulo 2^20. The quotient is needed to the same width, and the dividend fits in
   // 20 bits.
   localparam int AMB_SHIFT = 12 - 4;
   localparam int K_W       = AMB_SHIFT + CAL_W;
   localparam int DIV_STEPS = K_W;
   localparam logic [K_W-1:0] DIVIDEND = K_W'(4096 * 100);

   // Width of the duty product before the final shift.
   localparam int DUTY_SHIFT = 7;
   localparam int DUTY_P_W   = PERIOD_W + RISE_W;

   // Rise limits in sixteenths of a degree.
   localparam int RISE_MIN = 1 * 16;
   localparam int RISE_MAX = 8 * 16;

   // Register reset values.
   localparam logic [CAL_W-1:0]    CAL_LOW_RST  = CAL_W'(0);
   localparam logic [CAL_W-1:0]    CAL_HIGH_RST = CAL_W'(4095);
   localparam logic [CAL_W-1:0]    OFFSET_RST   = CAL_W'(750);
   localparam logic [PERIOD_W-1:0] PERIOD_RST   = PERIOD_W'(684);

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_CAL_LOW  = 2'd0,
      CSR_CAL_HIGH = 2'd1,
      CSR_OFFSET   = 2'd2,
      CSR_PERIOD   = 2'd3
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_FILT,
      ST_DUTY,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/fan_duty_from_temperature_rise.sv =====
// Top level: sequencer, configuration registers, rise filter and result word register.
//
// Fan duty from temperature rise.
// Each request word carries an ADC sample and an 8.8 external sensor reading. The block
// converts the sample to an 8.8 ambient temperature from the calibration registers, takes
// the clamped rise of the sensor over ambient, damps it against the previous rise and scales
// it by the PWM period. Each request word yields exactly one response word.
// Channels: req_ and rsp_ use valid/stall; a word moves on an edge with valid high and stall
// low. The csr_ channel writes one register per valid/ready edge and is always ready;
// write it only while the block is idle.
// Requests are processed one at a time: the sequencer runs the bit-serial divider, the radix-4
// calibration multiplier, the filter state and the duty multiplier in turn, and req_stall stays
// high until the result has been handed to the response register.
// The next request is taken while a finished response still waits in the output register.
// Reset loads the register defaults, clears the damping history and empties the pipeline.
// When the receiver stalls, the response word holds; a later result waits in the core
// and req_stall stays high until the response register frees.
module fan_duty_from_temperature_rise (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ftr_pkg::ADC_W-1:0]       req_adc_sample,
   input  logic [ftr_pkg::SENSOR_W-1:0]    req_sensor_temp,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ftr_pkg::TEMP_W-1:0]      rsp_ambient_temp,
   output logic [ftr_pkg::RISE_W-1:0]      rsp_damped_rise,
   output logic [ftr_pkg::TEMP_W-1:0]      rsp_duty_compare,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [ftr_pkg::PERIOD_W-1:0]    csr_data
);

   localparam int DIFF_W = ftr_pkg::TEMP_W + 1;
   localparam int RISE_S_W = DIFF_W - 4;
   localparam int SUM_W = ftr_pkg::RISE_W + 3;

   ftr_pkg::state_type state_ff, state_in;

   logic [ftr_pkg::CAL_W-1:0]    cal_low_ff, cal_low_in;
   logic [ftr_pkg::CAL_W-1:0]    cal_high_ff, cal_high_in;
   logic [ftr_pkg::CAL_W-1:0]    offset_ff, offset_in;
   logic [ftr_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [ftr_pkg::ADC_W-1:0]    adc_ff, adc_in;
   logic [ftr_pkg::SENSOR_W-1:0] sensor_ff, sensor_in;
   logic [ftr_pkg::TEMP_W-1:0]   ambient_ff, ambient_in;
   logic [ftr_pkg::RISE_W-1:0]   damped_ff, damped_in;
   logic [ftr_pkg::RISE_W-1:0]   last_damped_ff, last_damped_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ftr_pkg::TEMP_W-1:0]   rsp_ambient_ff, rsp_ambient_in;
   logic [ftr_pkg::RISE_W-1:0]   rsp_damped_ff, rsp_damped_in;
   logic [ftr_pkg::TEMP_W-1:0]   rsp_duty_ff, rsp_duty_in;

   logic                           accept;
   logic                           div_start, mul_start, duty_start;
   logic                           load_amb, load_filt, load_out, out_free;
   logic [ftr_pkg::SPAN_W-1:0]     span;
   logic [ftr_pkg::K_W-1:0]        quot;
   logic [ftr_pkg::K_W-1:0]        adc_delta;
   logic [ftr_pkg::K_W-1:0]        k_prod;
   logic [ftr_pkg::DUTY_P_W-1:0]   duty_prod;
   logic                           div_busy, div_done;
   logic                           mul_busy, mul_done;
   logic                           duty_busy, duty_done;
   logic [ftr_pkg::CAL_W-1:0]      amb_sum;
   logic signed [DIFF_W-1:0]       diff;
   logic signed [RISE_S_W-1:0]     rise;
   logic [ftr_pkg::RISE_W-1:0]     clamped;
   logic [SUM_W-1:0]               damp_sum;
   logic [ftr_pkg::RISE_W-1:0]     damped_new;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cal_low_in  = cal_low_ff;
      cal_high_in = cal_high_ff;
      offset_in   = offset_ff;
      period_in   = period_ff;
      if (csr_valid) begin
         unique case (ftr_pkg::csr_index_type'(csr_index))
            ftr_pkg::CSR_CAL_LOW:  cal_low_in  = csr_data[ftr_pkg::CAL_W-1:0];
            ftr_pkg::CSR_CAL_HIGH: cal_high_in = csr_data[ftr_pkg::CAL_W-1:0];
            ftr_pkg::CSR_OFFSET:   offset_in   = csr_data[ftr_pkg::CAL_W-1:0];
            ftr_pkg::CSR_PERIOD:   period_in   = csr_data;
            default: ;
         endcase
      end
   end

   // Calibration span and sample offset wrap like the unsigned arithmetic they model.
   assign span = {4'b0000, cal_high_ff} - {4'b0000, cal_low_ff};
   assign adc_delta = ftr_pkg::K_W'(adc_ff) - ftr_pkg::K_W'(cal_low_ff);

   ftr_sdiv u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .den   (span),
      .quot  (quot),
      .busy  (div_busy),
      .done  (div_done)
   );

   ftr_smul #(
      .A_W (ftr_pkg::K_W),
      .B_W (ftr_pkg::K_W),
      .P_W (ftr_pkg::K_W)
   ) u_kmul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (quot),
      .b     (adc_delta),
      .prod  (k_prod),
      .busy  (mul_busy),
      .done  (mul_done)
   );

   ftr_smul #(
      .A_W (ftr_pkg::PERIOD_W),
      .B_W (ftr_pkg::RISE_W),
      .P_W (ftr_pkg::DUTY_P_W)
   ) u_dmul (
      .clock (clock),
      .reset (reset),
      .start (duty_start),
      .a     (period_ff),
      .b     (damped_new),
      .prod  (duty_prod),
      .busy  (duty_busy),
      .done  (duty_done)
   );

   // Ambient: only 12 bits of the offset sum survive the shift left by four.
   assign amb_sum = k_prod[ftr_pkg::K_W-1:ftr_pkg::AMB_SHIFT] + offset_ff;

   // Rise over ambient, floored to sixteenths, clamped and damped with the previous value.
   assign diff = $signed({1'b0, sensor_ff}) - $signed({1'b0, ambient_ff});
   assign rise = RISE_S_W'(diff >>> 4);

   always_comb begin
      if (rise > RISE_S_W'(ftr_pkg::RISE_MAX)) begin
         clamped = ftr_pkg::RISE_W'(ftr_pkg::RISE_MAX);
      end else if (rise <= RISE_S_W'(ftr_pkg::RISE_MIN)) begin
         clamped = ftr_pkg::RISE_W'(ftr_pkg::RISE_MIN);
      end else begin
         clamped = rise[ftr_pkg::RISE_W-1:0];
      end
   end

   assign damp_sum = SUM_W'(clamped) + {last_damped_ff, 3'b000} - SUM_W'(last_damped_ff);
   assign damped_new = damp_sum[SUM_W-1:3];

   // Sequencer next state.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ftr_pkg::ST_IDLE: if (req_valid) state_in = ftr_pkg::ST_DIV;
         ftr_pkg::ST_DIV:  if (div_done) state_in = ftr_pkg::ST_MUL;
         ftr_pkg::ST_MUL:  if (mul_done) state_in = ftr_pkg::ST_FILT;
         ftr_pkg::ST_FILT: state_in = ftr_pkg::ST_DUTY;
         ftr_pkg::ST_DUTY: if (duty_done) state_in = ftr_pkg::ST_DONE;
         ftr_pkg::ST_DONE: if (out_free) state_in = ftr_pkg::ST_IDLE;
         default:          state_in = ftr_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall  = 1'b1;
      div_start  = 1'b0;
      mul_start  = 1'b0;
      duty_start = 1'b0;
      load_amb   = 1'b0;
      load_filt  = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         ftr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            div_start = req_valid;
         end
         ftr_pkg::ST_DIV:  mul_start = div_done;
         ftr_pkg::ST_MUL:  load_amb  = mul_done;
         ftr_pkg::ST_FILT: begin
            load_filt  = 1'b1;
            duty_start = 1'b1;
         end
         ftr_pkg::ST_DUTY: ;
         ftr_pkg::ST_DONE: load_out = out_free;
         default: ;
      endcase
   end

   assign accept = req_valid && !req_stall;

   // Datapath register updates.
   assign adc_in         = accept ? req_adc_sample : adc_ff;
   assign sensor_in      = accept ? req_sensor_temp : sensor_ff;
   assign ambient_in     = load_amb ? {amb_sum, 4'b0000} : ambient_ff;
   assign damped_in      = load_filt ? damped_new : damped_ff;
   assign last_damped_in = load_filt ? damped_new : last_damped_ff;

   // Response word register.
   assign rsp_valid_in   = load_out || (rsp_valid_ff && rsp_stall);
   assign rsp_ambient_in = load_out ? ambient_ff : rsp_ambient_ff;
   assign rsp_damped_in  = load_out ? damped_ff : rsp_damped_ff;
   assign rsp_duty_in    = load_out ?
                           duty_prod[ftr_pkg::DUTY_SHIFT +: ftr_pkg::TEMP_W] : rsp_duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ftr_pkg::ST_IDLE;
         cal_low_ff     <= ftr_pkg::CAL_LOW_RST;
         cal_high_ff    <= ftr_pkg::CAL_HIGH_RST;
         offset_ff      <= ftr_pkg::OFFSET_RST;
         period_ff      <= ftr_pkg::PERIOD_RST;
         last_damped_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cal_low_ff     <= cal_low_in;
         cal_high_ff    <= cal_high_in;
         offset_ff      <= offset_in;
         period_ff      <= period_in;
         last_damped_ff <= last_damped_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      adc_ff         <= adc_in;
      sensor_ff      <= sensor_in;
      ambient_ff     <= ambient_in;
      damped_ff      <= damped_in;
      rsp_ambient_ff <= rsp_ambient_in;
      rsp_damped_ff  <= rsp_damped_in;
      rsp_duty_ff    <= rsp_duty_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ambient_temp = rsp_ambient_ff;
   assign rsp_damped_rise  = rsp_damped_ff;
   assign rsp_duty_compare = rsp_duty_ff;

   // An accepted word always starts the divider in the next cycle.
   a_accept_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ftr_pkg::ST_DIV) && div_busy)
      else $error("accepted word did not start the divider");

   // The serial units run one after another, never together.
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      $countones({div_busy, mul_busy, duty_busy}) <= 1)
      else $error("more than one serial unit busy");

   // A new response word only comes from a finished computation.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ftr_pkg::ST_DONE))
      else $error("response raised outside the done state");

   // The damping history never leaves the clamp range ceiling.
   a_damped_max: assert property (@(posedge clock) disable iff (reset)
      last_damped_ff <= ftr_pkg::RISE_W'(ftr_pkg::RISE_MAX))
      else $error("damped rise above maximum");

endmodule

// ===== rtl/ftr_sdiv.sv =====
// Bit-serial restoring divider of the fixed dividend by the calibration span.
module ftr_sdiv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ftr_pkg::SPAN_W-1:0]    den,
   output logic [ftr_pkg::K_W-1:0]       quot,
   output logic                          busy,
   output logic                          done
);

   localparam int CNT_W = $clog2(ftr_pkg::DIV_STEPS + 1);

   logic [ftr_pkg::K_W-1:0]    num_ff, num_in;
   logic [ftr_pkg::K_W-1:0]    quot_ff, quot_in;
   logic [ftr_pkg::SPAN_W:0]   rem_ff, rem_in;
   logic [ftr_pkg::SPAN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [ftr_pkg::SPAN_W:0]   rem_sh;
   logic                       fits;
   logic                       last;

   // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
   // The partial remainder stays below the divisor, so 17 bits are enough.
   assign rem_sh = {rem_ff[ftr_pkg::SPAN_W-1:0], num_ff[ftr_pkg::K_W-1]};
   assign fits   = (rem_sh >= {1'b0, den_ff});
   assign last   = (cnt_ff == CNT_W'(ftr_pkg::DIV_STEPS - 1));

   always_comb begin
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = ftr_pkg::DIVIDEND;
         quot_in = '0;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in  = {num_ff[ftr_pkg::K_W-2:0], 1'b0};
         quot_in = {quot_ff[ftr_pkg::K_W-2:0], fits};
         rem_in  = fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         cnt_in  = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath registers are loaded at start.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign quot = quot_ff;
   assign busy = busy_ff;
   assign done = done_ff;

endmodule

// ===== rtl/ftr_smul.sv =====
// Digit-serial shift-and-add multiplier, two multiplier bits per cycle, product kept modulo 2^P_W.
module ftr_smul #(
   parameter int A_W = ftr_pkg::K_W,
   parameter int B_W = ftr_pkg::K_W,
   parameter int P_W = ftr_pkg::K_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] a,
   input  logic [B_W-1:0] b,
   output logic [P_W-1:0] prod,
   output logic           busy,
   output logic           done
);

   localparam int STEPS = (B_W + 1) / 2;
   localparam int B_PAD = 2 * STEPS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [P_W-1:0]   a_ff, a_in;
   logic [B_PAD-1:0] b_ff, b_in;
   logic [P_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [P_W-1:0]   pp;
   logic             last;

   // Partial product for the low radix-4 digit of the multiplier.
   assign pp   = (b_ff[0] ? a_ff : '0) + (b_ff[1] ? {a_ff[P_W-2:0], 1'b0} : '0);
   assign last = (cnt_ff == CNT_W'(STEPS - 1));

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = P_W'(a);
         b_in    = B_PAD'(b);
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         a_in   = {a_ff[P_W-3:0], 2'b00};
         b_in   = {2'b00, b_ff[B_PAD-1:2]};
         acc_in = acc_ff + pp;
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign prod = acc_ff;
   assign busy = busy_ff;
   assign done = done_ff;

endmodule

// ===== bench/ftr_checker.sv =====
// Checker for the fan duty block: predicts each response word and compares it field by field.
module ftr_checker
   import ftr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [ADC_W-1:0]    req_adc_sample,
   input  logic [SENSOR_W-1:0] req_sensor_temp,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [TEMP_W-1:0]   rsp_ambient_temp,
   input  logic [RISE_W-1:0]   rsp_damped_rise,
   input  logic [TEMP_W-1:0]   rsp_duty_compare,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [PERIOD_W-1:0] csr_data,
   output int                  fail_count,
   output int                  pending,
   output logic [TEMP_W-1:0]   last_ambient
);
   timeunit 1ns;
   timeprecision 1ps;

   // Calibration scale: 4096 counts times 100, divided by the span.
   localparam logic [31:0] CAL_SCALE     = 32'd409600;
   localparam int          READING_SHIFT = 8;

   typedef struct packed {
      logic [TEMP_W-1:0] ambient;
      logic [RISE_W-1:0] rise;
      logic [TEMP_W-1:0] duty;
   } fan_word_t;

   // Shadow copies of the registers and of the damping history.
   logic [CAL_W-1:0]    cal_low_q  = CAL_LOW_RST;
   logic [CAL_W-1:0]    cal_high_q = CAL_HIGH_RST;
   logic [CAL_W-1:0]    offset_q   = OFFSET_RST;
   logic [PERIOD_W-1:0] period_q   = PERIOD_RST;
   logic [RISE_W-1:0]   rise_hist  = '0;
   fan_word_t           awaited_q[$];

   // Ambient temperature, clamped and damped rise, and duty for one request word.
   function automatic fan_word_t predict_word(input logic [ADC_W-1:0]    adc,
                                              input logic [SENSOR_W-1:0] sensor,
                                              input logic [RISE_W-1:0]   history);
      fan_word_t   w;
      logic [15:0] span;
      logic [31:0] gain;
      logic [31:0] prod;
      logic [31:0] level;
      logic [31:0] clamped;
      logic [31:0] damped;
      logic [31:0] duty;
      int          diff;
      int          rise;
      span  = 16'(32'(cal_high_q) - 32'(cal_low_q));
      // A zero span makes the restoring divider return all ones.
      gain  = (span == 16'd0) ? '1 : CAL_SCALE / 32'(span);
      prod  = gain * (32'(adc) - 32'(cal_low_q));
      level = (prod >> READING_SHIFT) + 32'(offset_q);
      w.ambient = TEMP_W'(level << 4);
      // The rise is floored to sixteenths, then clamped.
      diff = int'(sensor) - int'(w.ambient);
      rise = diff >>> 4;
      if (rise > RISE_MAX) begin
         clamped = 32'(RISE_MAX);
      end else if (rise <= RISE_MIN) begin
         clamped = 32'(RISE_MIN);
      end else begin
         clamped = 32'(rise);
      end
      damped = (clamped + 32'd7 * 32'(history)) >> 3;
      duty   = (32'(period_q) * damped) >> DUTY_SHIFT;
      w.rise = RISE_W'(damped);
      w.duty = TEMP_W'(duty);
      return w;
   endfunction

   // Prints one line per mismatch and counts every one.
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("%0t ns: mismatch on %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
      fail_count++;
   endtask

   // Watch the three channels at each rising edge.
   always @(posedge clock) begin
      fan_word_t got;
      fan_word_t want;
      if (reset) begin
         cal_low_q  <= CAL_LOW_RST;
         cal_high_q <= CAL_HIGH_RST;
         offset_q   <= OFFSET_RST;
         period_q   <= PERIOD_RST;
         rise_hist  <= '0;
         awaited_q.delete();
         pending    <= 0;
      end else begin
         // Response words are compared against the oldest expectation.
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_ambient_temp, rsp_damped_rise, rsp_duty_compare};
            if (awaited_q.size() == 0) begin
               report_mismatch("response word with nothing expected", 32'(got.ambient), 0);
            end else begin
               want = awaited_q.pop_front();
               if (got.ambient !== want.ambient)
                  report_mismatch("ambient_temp", 32'(got.ambient), 32'(want.ambient));
               if (got.rise !== want.rise)
                  report_mismatch("damped_rise", 32'(got.rise), 32'(want.rise));
               if (got.duty !== want.duty)
                  report_mismatch("duty_compare", 32'(got.duty), 32'(want.duty));
            end
         end

         // Each accepted request word yields exactly one expected response word.
         if (req_valid && !req_stall) begin
            want = predict_word(req_adc_sample, req_sensor_temp, rise_hist);
            awaited_q.push_back(want);
            rise_hist    <= want.rise;
            last_ambient <= want.ambient;
         end

         // Register writes; the index field covers exactly the four registers.
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_CAL_LOW:  cal_low_q  <= CAL_W'(csr_data);
               CSR_CAL_HIGH: cal_high_q <= CAL_W'(csr_data);
               CSR_OFFSET:   offset_q   <= CAL_W'(csr_data);
               CSR_PERIOD:   period_q   <= csr_data;
               default: ;
            endcase
         end

         pending <= awaited_q.size();
      end
   end

endmodule

// ===== bench/fan_duty_from_temperature_rise_tb.sv =====
// Testbench top for the fan duty block: clock, reset, stimulus, back-pressure and verdict.
module fan_duty_from_temperature_rise_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ftr_pkg::*;

   localparam int DRAIN_LIMIT   = 100000;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_WORDS   = 250;
   localparam int RANDOM_PHASES = 8;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [ADC_W-1:0]    req_adc_sample  = '0;
   logic [SENSOR_W-1:0] req_sensor_temp = '0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [TEMP_W-1:0]   rsp_ambient_temp;
   logic [RISE_W-1:0]   rsp_damped_rise;
   logic [TEMP_W-1:0]   rsp_duty_compare;
   logic                csr_valid       = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_index       = '0;
   logic [PERIOD_W-1:0] csr_data        = '0;

   int                  fail_count;
   int                  pending;
   logic [TEMP_W-1:0]   last_ambient;

   logic                req_fire    = 1'b0;
   logic                csr_fire    = 1'b0;
   int unsigned         idle_pct    = 0;
   int unsigned         stall_pct   = 0;
   logic                hold_toggle = 1'b0;
   logic                hold_ack    = 1'b0;
   int                  hold_left   = 0;

   always #10 clock = ~clock;

   fan_duty_from_temperature_rise dut (.*);

   ftr_checker duty_watch (.*);

   // Handshake outcomes captured at the rising edge, read at the falling edge.
   always @(posedge clock) begin
      req_fire <= req_valid && !req_stall;
      csr_fire <= csr_valid && csr_ready;
   end

   // Receiver: random stalls, plus a long hold-off each time one is requested.
   always @(negedge clock) begin
      if (hold_toggle != hold_ack) begin
         hold_ack  <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offers one request word after random idle cycles and waits until it is taken.
   task automatic send_word(input logic [ADC_W-1:0] adc, input logic [SENSOR_W-1:0] sensor);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_adc_sample  <= adc;
      req_sensor_temp <= sensor;
      @(negedge clock);
      while (!req_fire) @(negedge clock);
   endtask

   // Sends a sensor reading a given lead above the ambient of the previous word.
   task automatic send_near(input logic [ADC_W-1:0] adc, input int lead);
      send_word(adc, SENSOR_W'(int'(last_ambient) + lead));
   endtask

   // Waits until every expected response word has arrived.
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [PERIOD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_fire) @(negedge clock);
   endtask

   // Loads all four registers once the block is idle; unused upper data bits are random.
   task automatic load_setting(input logic [CAL_W-1:0] lo, input logic [CAL_W-1:0] hi,
                               input logic [CAL_W-1:0] off, input logic [PERIOD_W-1:0] period);
      drain();
      write_reg(CSR_CAL_LOW, {4'($urandom), lo});
      write_reg(CSR_CAL_HIGH, {4'($urandom), hi});
      write_reg(CSR_OFFSET, {4'($urandom), off});
      write_reg(CSR_PERIOD, period);
      csr_valid <= 1'b0;
   endtask

   // Run limit.
   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [ADC_W-1:0] adc_q;
      logic [CAL_W-1:0] lo;
      logic [CAL_W-1:0] hi;
      adc_q = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Field extremes with the reset settings, then the clamp boundaries.
      send_word('0, '0);
      send_word('1, '1);
      send_word('1, '0);
      send_word('0, '1);
      send_word(12'd1234, 16'($urandom));
      send_near(12'd1234, -1);
      send_near(12'd1234, 16 * 16);
      send_near(12'd1234, 17 * 16);
      send_near(12'd1234, 128 * 16);
      send_near(12'd1234, 129 * 16);

      // Zero calibration span, including a sample below the low point.
      load_setting(12'd2048, 12'd2048, 12'd0, 16'hFFFF);
      send_word(12'd2048, 16'h0800);
      send_word(12'd2049, 16'h4000);
      send_word(12'd0, 16'hFFFF);

      // High point below the low point, and a zero period.
      load_setting(12'hFFF, 12'd0, 12'hFFF, 16'd0);
      send_word(12'd0, 16'h1234);
      send_word(12'hFFF, 16'hFFFF);
      send_word(12'd100, 16'h8000);

      // Smallest span gives the largest gain; smallest non-zero period.
      load_setting(12'd0, 12'd1, 12'hFFF, 16'd1);
      send_word(12'hFFF, 16'hFFFF);
      send_word(12'd1, 16'h0000);

      // Random phases: mostly readings aimed just above ambient so the filter
      // sees rises inside the clamp window, the rest fully random.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            3: load_setting(12'($urandom_range(0, 2000)), 12'($urandom_range(2100, 4095)),
                            12'd0, 16'd1);
            5: load_setting(12'($urandom), 12'($urandom), 12'($urandom),
                            16'($urandom_range(1, 65535)));
            7: load_setting(12'd0, 12'hFFF, 12'hFFF, 16'hFFFF);
            default: begin
               lo = 12'($urandom_range(0, 2000));
               hi = lo + 12'($urandom_range(200, 2095));
               load_setting(lo, hi, 12'($urandom), 16'($urandom_range(1, 65535)));
            end
         endcase
         case (phase % 4)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct = 73;
               stall_pct <= 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct <= 73;
            end
            default: begin
               idle_pct = 24;
               stall_pct <= 24;
            end
         endcase
         // The receiver holds off while words keep coming, so the block backs up.
         if (phase == 0) hold_toggle <= ~hold_toggle;
         repeat (PHASE_WORDS) begin
            if ($urandom_range(99) < 70) begin
               send_near(adc_q, int'($urandom_range(0, 2600)) - 300);
            end else begin
               adc_q = ADC_W'($urandom);
               send_word(adc_q, SENSOR_W'($urandom));
            end
         end
      end

      drain();
      repeat (50) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ftr_pkg.sv
rtl/ftr_sdiv.sv
rtl/ftr_smul.sv
rtl/fan_duty_from_temperature_rise.sv
bench/ftr_checker.sv
bench/fan_duty_from_temperature_rise_tb.sv
